>>> hdl/ipvd_pkg.sv
// ipvd_pkg: widths, constants, control word types and the microcode table
// of the incremental pid valve drive; used by every module of the block.
// depends on nothing.
package ipvd_pkg;

  // default geometry
  localparam int CHANNELS_DEF = 4;
  localparam int DAC_BITS_DEF = 12;

  // fixed field and register widths
  localparam int CH_W     = 2;
  localparam int PRESS_W  = 16;
  localparam int IN_W     = 40;
  localparam int CFG_W    = 64;
  localparam int LANE_W   = 16;
  localparam int FRAC_W   = 16;

  // datapath widths
  localparam int ERR_W    = 17;
  localparam int DERR_W   = 18;
  localparam int ESUM_W   = 17;
  localparam int MUL_A_W  = 18;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = 35;
  localparam int ACC_W    = 36;
  localparam int INC_W    = 42;
  localparam int LSUM_W   = INC_W + 1;

  // shared divider geometry
  localparam int DIV_W     = 52;
  localparam int DIVISOR_W = 16;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // constants of the control law
  localparam logic [PRESS_W-1:0] LOW_TARGET       = 16'd6;
  localparam logic [PRESS_W-1:0] LOW_TARGET_VALUE = 16'd3;
  localparam logic [MUL_B_W-1:0] GAIN_SCALE       = 17'd10000;

  // configuration register indexes
  localparam logic [1:0] REG_KP  = 2'd0;
  localparam logic [1:0] REG_KI  = 2'd1;
  localparam logic [1:0] REG_KD  = 2'd2;
  localparam logic [1:0] REG_LIM = 2'd3;

  // jump conditions of the sequencer
  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_BAD_CH   = 3'd1,
    COND_KI_ZERO  = 3'd2,
    COND_DIV_BUSY = 3'd3,
    COND_OUT_FULL = 3'd4
  } cond_t;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_SUM = 2'd0,  // err * 10000
    MUL_P   = 2'd1,  // err * kp
    MUL_D   = 2'd2   // derr * kd
  } mul_sel_t;

  // divider operand pairs
  typedef enum logic {
    DIV_PD  = 1'b0,  // (p + d) * 2^16 / 10000
    DIV_INT = 1'b1   // sum * 2^16 / ki
  } div_sel_t;

  localparam int STEP_W = 4;

  // program steps
  localparam logic [STEP_W-1:0] ST_CHECK  = 4'd0;
  localparam logic [STEP_W-1:0] ST_SUM    = 4'd1;
  localparam logic [STEP_W-1:0] ST_PTERM  = 4'd2;
  localparam logic [STEP_W-1:0] ST_DTERM  = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIV1   = 4'd4;
  localparam logic [STEP_W-1:0] ST_WAIT1  = 4'd5;
  localparam logic [STEP_W-1:0] ST_INC1   = 4'd6;
  localparam logic [STEP_W-1:0] ST_DIV2   = 4'd7;
  localparam logic [STEP_W-1:0] ST_WAIT2  = 4'd8;
  localparam logic [STEP_W-1:0] ST_INC2   = 4'd9;
  localparam logic [STEP_W-1:0] ST_LEVEL  = 4'd10;
  localparam logic [STEP_W-1:0] ST_OUT    = 4'd11;

  // one control word
  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              last;
    mul_sel_t          mul_sel;
    logic              mul_en;
    logic              derr_load;
    logic              sum_upd;
    logic              acc_load;
    logic              acc_add;
    logic              hist_upd;
    div_sel_t          div_sel;
    logic              div_start;
    logic              inc_load;
    logic              inc_add;
    logic              lvl_upd;
    logic              out_load;
  } ucode_t;

  // status from the datapath for conditional jumps
  typedef struct packed {
    logic bad_ch;
    logic ki_zero;
    logic div_busy;
    logic out_full;
  } seq_status_t;

  localparam ucode_t UC_NOP = '{
    cond: COND_NONE, target: ST_CHECK, last: 1'b0, mul_sel: MUL_SUM, mul_en: 1'b0,
    derr_load: 1'b0, sum_upd: 1'b0, acc_load: 1'b0, acc_add: 1'b0, hist_upd: 1'b0,
    div_sel: DIV_PD, div_start: 1'b0, inc_load: 1'b0, inc_add: 1'b0, lvl_upd: 1'b0,
    out_load: 1'b0
  };

  // program rom
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc = UC_NOP;
    unique case (step)
      ST_CHECK: begin
        uc.mul_sel   = MUL_SUM;
        uc.mul_en    = 1'b1;
        uc.derr_load = 1'b1;
        uc.cond      = COND_BAD_CH;
        uc.target    = ST_OUT;
      end
      ST_SUM: begin
        uc.sum_upd = 1'b1;
        uc.mul_sel = MUL_P;
        uc.mul_en  = 1'b1;
      end
      ST_PTERM: begin
        uc.acc_load = 1'b1;
        uc.mul_sel  = MUL_D;
        uc.mul_en   = 1'b1;
        uc.hist_upd = 1'b1;
      end
      ST_DTERM: begin
        uc.acc_add = 1'b1;
      end
      ST_DIV1: begin
        uc.div_sel   = DIV_PD;
        uc.div_start = 1'b1;
      end
      ST_WAIT1: begin
        uc.cond   = COND_DIV_BUSY;
        uc.target = ST_WAIT1;
      end
      ST_INC1: begin
        uc.inc_load = 1'b1;
        uc.cond     = COND_KI_ZERO;
        uc.target   = ST_LEVEL;
      end
      ST_DIV2: begin
        uc.div_sel   = DIV_INT;
        uc.div_start = 1'b1;
      end
      ST_WAIT2: begin
        uc.cond   = COND_DIV_BUSY;
        uc.target = ST_WAIT2;
      end
      ST_INC2: begin
        uc.inc_add = 1'b1;
      end
      ST_LEVEL: begin
        uc.lvl_upd = 1'b1;
      end
      ST_OUT: begin
        uc.out_load = 1'b1;
        uc.last     = 1'b1;
        uc.cond     = COND_OUT_FULL;
        uc.target   = ST_OUT;
      end
      default: begin
        uc = UC_NOP;
      end
    endcase
    return uc;
  endfunction

endpackage

>>> hdl/incremental_pid_valve_drive.sv
// incremental_pid_valve_drive: top level; per-channel loop state, gain
// registers, multiplier and level datapath around the microcoded sequencer.
// depends on ipvd_pkg, ipvd_seq and ipvd_div.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: channel, target, measured
//  m_*       out        m_tvalid/m_tready  m_tdata: out_channel, dac_code
//  cfg_*     in         cfg_we             cfg_addr, cfg_wdata
//
// an item occupies the sequencer from acceptance to the next acceptance;
// it runs both passes of the shared divider when the channel's integral
// divisor is nonzero, only the first when it is zero, and skips to the
// result step for a channel number at or above CHANNELS.
// rst is synchronous and clears all loop state, the gain registers and both
// handshakes. a new item is taken while a result still waits in m_tdata;
// the sequencer holds in its last step until that result is taken.
module incremental_pid_valve_drive
  import ipvd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int DAC_BITS = DAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // channel [1:0], target [17:2], measured [33:18]
  input  logic [IN_W-1:0]                         s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // out_channel [1:0], dac_code [DAC_BITS+1:2]
  output logic [((CH_W + DAC_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic                                    cfg_we,
  input  logic [1:0]                              cfg_addr,
  input  logic [CFG_W-1:0]                        cfg_wdata
);

  localparam int OUT_W    = ((CH_W + DAC_BITS + 7) / 8) * 8;
  localparam int LVL_W    = DAC_BITS + FRAC_W;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W:0]      CH_COUNT = (CH_W + 1)'(CHANNELS);
  localparam logic [LVL_W-1:0]   LVL_TOP  = {{DAC_BITS{1'b1}}, {FRAC_W{1'b0}}};

  // gain registers
  logic [CFG_W-1:0] cfg_kp;
  logic [CFG_W-1:0] cfg_ki;
  logic [CFG_W-1:0] cfg_kd;
  logic [CFG_W-1:0] cfg_lim;

  // per-channel loop state
  logic signed [ESUM_W-1:0] esum  [CHANNELS];
  logic signed [ERR_W-1:0]  elast [CHANNELS];
  logic signed [ERR_W-1:0]  eprev [CHANNELS];
  logic [LVL_W-1:0]         level [CHANNELS];

  // item registers
  logic [CH_W-1:0]          ch_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DERR_W-1:0] derr_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [INC_W-1:0]  inc_r;
  logic                     div_neg;

  // control
  ucode_t      ctrl;
  seq_status_t status;
  logic        seq_busy;
  logic        accept;
  logic        div_busy;
  logic [DIV_W-1:0] div_quo;
  logic        div_rem_nz;

  // input unpack
  logic [CH_W-1:0]    in_ch;
  logic [PRESS_W-1:0] in_target;
  logic [PRESS_W-1:0] in_measured;
  logic [PRESS_W-1:0] tgt_adj;

  assign in_ch       = s_tdata[CH_W-1:0];
  assign in_target   = s_tdata[CH_W +: PRESS_W];
  assign in_measured = s_tdata[CH_W + PRESS_W +: PRESS_W];
  assign tgt_adj     = (in_target < LOW_TARGET) ? LOW_TARGET_VALUE : in_target;

  assign s_tready = !seq_busy;
  assign accept   = s_tvalid && s_tready;

  // channel lane and its gains
  logic [IDX_W-1:0]  idx;
  logic              bad_ch;
  logic [LANE_W-1:0] kp;
  logic [LANE_W-1:0] ki;
  logic [LANE_W-1:0] kd;
  logic [LANE_W-1:0] lim;

  assign idx    = ch_r[IDX_W-1:0];
  assign bad_ch = {1'b0, ch_r} >= CH_COUNT;
  assign kp     = cfg_kp[{ch_r, 4'd0} +: LANE_W];
  assign ki     = cfg_ki[{ch_r, 4'd0} +: LANE_W];
  assign kd     = cfg_kd[{ch_r, 4'd0} +: LANE_W];
  assign lim    = cfg_lim[{ch_r, 4'd0} +: LANE_W];

  assign status.bad_ch   = bad_ch;
  assign status.ki_zero  = ki == '0;
  assign status.div_busy = div_busy;
  assign status.out_full = m_tvalid && !m_tready;

  ipvd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .status (status),
    .ctrl   (ctrl),
    .busy   (seq_busy)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_kp  <= '0;
      cfg_ki  <= '0;
      cfg_kd  <= '0;
      cfg_lim <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KP:  cfg_kp  <= cfg_wdata;
        REG_KI:  cfg_ki  <= cfg_wdata;
        REG_KD:  cfg_kd  <= cfg_wdata;
        REG_LIM: cfg_lim <= cfg_wdata;
      endcase
    end
  end

  // item capture and error
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r  <= in_ch;
      err_r <= $signed({1'b0, tgt_adj}) - $signed({1'b0, in_measured});
    end
  end

  // shared multiplier, registered product
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_full;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_P: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = $signed({1'b0, kp});
      end
      MUL_D: begin
        mul_a = derr_r;
        mul_b = $signed({1'b0, kd});
      end
      default: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = $signed(GAIN_SCALE);
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_full;
    end
    if (ctrl.derr_load) begin
      derr_r <= DERR_W'(elast[idx]) - DERR_W'(eprev[idx]);
    end
    if (ctrl.acc_load) begin
      acc_r <= ACC_W'(prod_r);
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // integral sum with clamp
  logic signed [ACC_W-1:0]  sum_tmp;
  logic signed [ACC_W-1:0]  lim_s;
  logic signed [ESUM_W-1:0] sum_new;

  always_comb begin
    sum_tmp = ACC_W'(esum[idx]) + ACC_W'(prod_r);
    lim_s   = $signed({{(ACC_W - LANE_W){1'b0}}, lim});
    if (sum_tmp > lim_s) begin
      sum_new = ESUM_W'(lim_s);
    end else if (sum_tmp < -lim_s) begin
      sum_new = ESUM_W'(-lim_s);
    end else begin
      sum_new = sum_tmp[ESUM_W-1:0];
    end
  end

  // divider operands
  logic [ACC_W-1:0]     acc_mag;
  logic [ESUM_W-1:0]    sum_mag;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 op_neg;

  always_comb begin
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    sum_mag = esum[idx][ESUM_W-1] ? ESUM_W'(-esum[idx]) : ESUM_W'(esum[idx]);
    case (ctrl.div_sel)
      DIV_INT: begin
        div_dividend = DIV_W'({sum_mag, {FRAC_W{1'b0}}});
        div_divisor  = ki;
        op_neg       = esum[idx][ESUM_W-1];
      end
      default: begin
        div_dividend = DIV_W'({acc_mag, {FRAC_W{1'b0}}});
        div_divisor  = DIVISOR_W'(GAIN_SCALE);
        op_neg       = acc_r[ACC_W-1];
      end
    endcase
  end

  ipvd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  // floor-rounded signed quotient
  logic signed [INC_W-1:0] q_mag;
  logic signed [INC_W-1:0] q_floor;

  always_comb begin
    q_mag = $signed({1'b0, div_quo[INC_W-2:0]});
    if (!div_neg) begin
      q_floor = q_mag;
    end else if (div_rem_nz) begin
      q_floor = ~q_mag;
    end else begin
      q_floor = -q_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      div_neg <= op_neg;
    end
    if (ctrl.inc_load) begin
      inc_r <= q_floor;
    end else if (ctrl.inc_add) begin
      inc_r <= inc_r + q_floor;
    end
  end

  // new drive level, floored at zero and saturated at the top code
  logic signed [LSUM_W-1:0] lvl_sum;
  logic [LVL_W-1:0]         lvl_new;

  always_comb begin
    lvl_sum = $signed(LSUM_W'(level[idx])) + LSUM_W'(inc_r);
    if (lvl_sum <= 0) begin
      lvl_new = '0;
    end else if (lvl_sum > $signed(LSUM_W'(LVL_TOP))) begin
      lvl_new = LVL_TOP;
    end else begin
      lvl_new = lvl_sum[LVL_W-1:0];
    end
  end

  // loop state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        esum[c]  <= '0;
        elast[c] <= '0;
        eprev[c] <= '0;
        level[c] <= '0;
      end
    end else begin
      if (ctrl.sum_upd) begin
        esum[idx] <= sum_new;
      end
      if (ctrl.hist_upd) begin
        eprev[idx] <= elast[idx];
        elast[idx] <= err_r;
      end
      if (ctrl.lvl_upd) begin
        level[idx] <= lvl_new;
      end
    end
  end

  // result register
  logic [DAC_BITS-1:0] dac_code;

  assign dac_code = bad_ch ? '0 : level[idx][LVL_W-1 -: DAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {{(OUT_W - CH_W - DAC_BITS){1'b0}}, dac_code, ch_r};
    end
  end

  // an accepted item starts the program
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    accept |=> seq_busy)
    else $error("accepted item did not start the sequencer");

  // the divider is never restarted mid-division
  a_div_idle : assert property (@(posedge clk) disable iff (rst)
    ctrl.div_start |-> !div_busy)
    else $error("divider started while busy");

  // a result never overwrites one still waiting
  a_out_free : assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a waiting result");

endmodule

>>> hdl/ipvd_div.sv
// ipvd_div: shared unsigned restoring divider, two quotient bits per cycle.
// gives the quotient and whether a remainder is left, for floor rounding.
// depends on ipvd_pkg.
module ipvd_div
  import ipvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_W-1:0]     quotient,
  output logic                 rem_nz
);

  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     quo_next;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIVISOR_W-1:0] dsr;
  logic [DCNT_W-1:0]    cnt;

  // two dependent shift-subtract steps
  always_comb begin
    logic [DIVISOR_W:0] trial;
    logic               ge;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      ge       = trial >= {1'b0, dsr};
      quo_next = {quo_next[DIV_W-2:0], ge};
      rem_next = ge ? DIVISOR_W'(trial - {1'b0, dsr}) : trial[DIVISOR_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;
  assign rem_nz   = rem != '0;

endmodule

>>> hdl/ipvd_seq.sv
// ipvd_seq: step counter and program rom; issues one control word per step
// and takes conditional jumps on datapath status.
// depends on ipvd_pkg.
module ipvd_seq
  import ipvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  seq_status_t status,
  output ucode_t      ctrl,
  output logic        busy
);

  logic [STEP_W-1:0] step;
  ucode_t            cw;
  logic              jump;

  assign cw = ucode_rom(step);

  // jump condition
  always_comb begin
    unique case (cw.cond)
      COND_NONE:     jump = 1'b0;
      COND_BAD_CH:   jump = status.bad_ch;
      COND_KI_ZERO:  jump = status.ki_zero;
      COND_DIV_BUSY: jump = status.div_busy;
      COND_OUT_FULL: jump = status.out_full;
      default:       jump = 1'b0;
    endcase
  end

  // control word to the datapath; the result is loaded only on fall-through
  always_comb begin
    ctrl = UC_NOP;
    if (busy) begin
      ctrl          = cw;
      ctrl.out_load = cw.out_load & ~jump;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_CHECK;
    end else if (start) begin
      busy <= 1'b1;
      step <= ST_CHECK;
    end else if (busy) begin
      if (cw.last && !jump) begin
        busy <= 1'b0;
      end
      step <= jump ? cw.target : step + 1'b1;
    end
  end

endmodule

>>> tb/sv/tb_incremental_pid_valve_drive.sv
// tb_incremental_pid_valve_drive: self-checking bench for the incremental pid valve drive;
// a local predictor of the per-channel loops checks every drive code on the result stream.
// depends on ipvd_pkg and incremental_pid_valve_drive.
module tb_incremental_pid_valve_drive
  import ipvd_pkg::*;
;

  localparam int  OUT_W     = ((CH_W + DAC_BITS_DEF + 7) / 8) * 8;
  localparam int  LIMIT     = 1_000_000;
  localparam int  SETTINGS  = 6;
  localparam int  TAIL      = 80;
  localparam longint SCALE  = 10000;
  localparam longint TOP_Q16 = ((longint'(1) << DAC_BITS_DEF) - 1) << FRAC_W;

  typedef struct {
    logic [CH_W-1:0]    ch;
    logic [PRESS_W-1:0] target;
    logic [PRESS_W-1:0] measured;
  } valve_cmd_t;

  typedef struct {
    logic [CH_W-1:0]         ch;
    logic [DAC_BITS_DEF-1:0] code;
  } drive_code_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_addr = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // pacing of both sides, in percent of cycles spent idle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  valve_cmd_t  pending_cmds[$];
  drive_code_t expected_codes[$];

  // predictor copy of the gain registers and of the loop state
  logic [CFG_W-1:0] gain_regs[4] = '{default: '0};
  longint err_sum[4]   = '{default: 0};
  longint err_last[4]  = '{default: 0};
  longint err_prior[4] = '{default: 0};
  longint level_q16[4] = '{default: 0};

  int items_taken     = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int cycles          = 0;

  incremental_pid_valve_drive dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // division rounding toward minus infinity, divisor positive
  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // one loop step of a channel; updates the predicted state
  function automatic drive_code_t advance_loop(input valve_cmd_t c);
    drive_code_t r;
    longint tgt, err, kp, ki, kd, lim, derr, acc, inc, lvl;
    int ch;
    ch = int'(c.ch);
    r.ch = c.ch;
    tgt = (c.target < LOW_TARGET) ? longint'(LOW_TARGET_VALUE) : longint'(c.target);
    err = tgt - longint'(c.measured);
    kp  = longint'(gain_regs[REG_KP][16*ch +: 16]);
    ki  = longint'(gain_regs[REG_KI][16*ch +: 16]);
    kd  = longint'(gain_regs[REG_KD][16*ch +: 16]);
    lim = longint'(gain_regs[REG_LIM][16*ch +: 16]);
    // integral sum, clamped to the channel limit
    err_sum[ch] = err_sum[ch] + err * SCALE;
    if (err_sum[ch] > lim) err_sum[ch] = lim;
    else if (err_sum[ch] < -lim) err_sum[ch] = -lim;
    // derivative from the two previous errors
    derr = err_last[ch] - err_prior[ch];
    err_prior[ch] = err_last[ch];
    err_last[ch]  = err;
    acc = kp * err + kd * derr;
    inc = floor_div(acc * (longint'(1) << FRAC_W), SCALE);
    // a zero divisor drops the integral term
    if (ki != 0) inc = inc + floor_div(err_sum[ch] * (longint'(1) << FRAC_W), ki);
    lvl = level_q16[ch] + inc;
    if (lvl <= 0) lvl = 0;
    if (lvl > TOP_Q16) lvl = TOP_Q16;
    level_q16[ch] = lvl;
    r.code = DAC_BITS_DEF'(lvl >> FRAC_W);
    return r;
  endfunction

  // gain lane, mostly small so the level moves without pinning
  function automatic logic [15:0] rand_lane();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return 16'($urandom_range(2000));
    else if (pick < 8) return 16'($urandom_range(20000));
    else return 16'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg();
    return {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
  endfunction

  function automatic valve_cmd_t random_cmd();
    valve_cmd_t c;
    int pick, t;
    c.ch = CH_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 60) begin
      // tracking: target close to the measurement
      c.measured = 16'($urandom);
      t = int'(c.measured) + int'($urandom_range(400)) - 200;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      c.target = 16'(t);
    end else if (pick < 72) begin
      // targets around the low-target threshold
      c.target   = 16'($urandom_range(7));
      c.measured = 16'($urandom_range(40));
    end else if (pick < 90) begin
      c.target   = 16'($urandom);
      c.measured = 16'($urandom);
    end else begin
      c.target   = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      c.measured = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return c;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_regs[idx] = val;
  endtask

  task automatic load_setting(input int idx);
    logic [CFG_W-1:0] kp, ki, kd, lim;
    case (idx)
      0: begin
        kp  = {16'd65535, 16'd1, 16'd5000, 16'd10000};
        ki  = {16'd65535, 16'd1, 16'd10000, 16'd0};
        kd  = {16'd123, 16'd65535, 16'd10000, 16'd0};
        lim = {16'd500, 16'd0, 16'd10000, 16'd65535};
      end
      1: begin
        kp = '1; ki = '1; kd = '1; lim = '1;
      end
      2: begin
        kp = '0; ki = '0; kd = '0; lim = '0;
      end
      4: begin
        // integral dominated, smallest divisors
        kp  = rand_reg();
        ki  = {16'd65535, 16'd100, 16'd2, 16'd1};
        kd  = '0;
        lim = '1;
      end
      default: begin
        kp = rand_reg(); ki = rand_reg(); kd = rand_reg(); lim = rand_reg();
      end
    endcase
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_LIM, lim);
  endtask

  // saturation, floor at zero, low target and threshold per channel
  task automatic queue_directed();
    valve_cmd_t c;
    for (int ch = 0; ch < 4; ch++) begin
      c.ch = CH_W'(ch);
      c.target = 16'hFFFF; c.measured = 16'h0000; pending_cmds.push_back(c);
      c.target = 16'h0000; c.measured = 16'hFFFF; pending_cmds.push_back(c);
      c.target = 16'd5;    c.measured = 16'd2;    pending_cmds.push_back(c);
      c.target = 16'd6;    c.measured = 16'd0;    pending_cmds.push_back(c);
      c.target = 16'd1000; c.measured = 16'd990;  pending_cmds.push_back(c);
    end
  endtask

  // wait until every input item is taken and every result item checked
  task automatic drain();
    do begin
      while (pending_cmds.size() != 0 || s_tvalid || expected_codes.size() != 0)
        @(posedge clk);
      repeat (TAIL) @(posedge clk);
    end while (pending_cmds.size() != 0 || s_tvalid || expected_codes.size() != 0);
  endtask

  // input item driver
  always @(posedge clk) begin
    valve_cmd_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_cmds.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
        nxt = pending_cmds.pop_front();
        s_tdata  <= {{(IN_W - CH_W - 2 * PRESS_W){1'b0}}, nxt.measured, nxt.target, nxt.ch};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= int'($urandom_range(99)) >= recv_idle_pct;
    end
  end

  // predict on each accepted input item, check each accepted result item
  always @(posedge clk) begin
    drive_code_t want;
    valve_cmd_t  got_cmd;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_codes.size() == 0) begin
          fail_count++;
          $error("drive code with nothing pending: out_channel %0d dac_code %0d",
                 m_tdata[1:0], m_tdata[DAC_BITS_DEF+1:2]);
        end else begin
          want = expected_codes.pop_front();
          results_checked++;
          if (m_tdata[1:0] !== want.ch) begin
            fail_count++;
            if (fail_count < 200)
              $error("out_channel: expected %0d, got %0d", want.ch, m_tdata[1:0]);
          end
          if (m_tdata[DAC_BITS_DEF+1:2] !== want.code) begin
            fail_count++;
            if (fail_count < 200)
              $error("dac_code: expected %0d, got %0d", want.code,
                     m_tdata[DAC_BITS_DEF+1:2]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        got_cmd.ch       = s_tdata[1:0];
        got_cmd.target   = s_tdata[17:2];
        got_cmd.measured = s_tdata[33:18];
        expected_codes.push_back(advance_loop(got_cmd));
        items_taken++;
      end
    end
  end

  // run watchdog
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("incremental_pid_valve_drive: mismatch");
    $finish;
  end

  // reset, then phases of gain settings and pacing modes
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < SETTINGS; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 8;  recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      load_setting(ph);
      if (ph == 0) queue_directed();
      repeat ((ph == 0) ? 222 : 246) pending_cmds.push_back(random_cmd());
      drain();
    end
    if (expected_codes.size() != 0) begin
      fail_count++;
      $error("%0d drive codes never arrived", expected_codes.size());
    end
    $display("ran %0d input items over %0d gain settings and three pacing modes",
             items_taken, SETTINGS);
    $display("checked %0d drive codes, %0d failures", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("incremental_pid_valve_drive: match");
    end else begin
      $display("incremental_pid_valve_drive: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ipvd_pkg.sv
hdl/ipvd_div.sv
hdl/ipvd_seq.sv
hdl/incremental_pid_valve_drive.sv
tb/sv/tb_incremental_pid_valve_drive.sv
